[hw/rtl/cubic_hermite_interpolator_top_macros.svh]
// Assertion macros used by the cubic Hermite interpolator top level.
`ifndef CUBIC_HERMITE_INTERPOLATOR_TOP_MACROS_SVH
`define CUBIC_HERMITE_INTERPOLATOR_TOP_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define CHP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define CHP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/chp_pkg.sv]
// Shared types, constants and saturating helpers of the cubic Hermite interpolator.
`default_nettype none

package chp_pkg;

    localparam int WIDE_W     = 64;
    localparam int IN_FIELDS  = 7;
    localparam int QMUL_LAT   = 4;
    localparam int EVAL_LEAD  = 10;
    localparam int EVAL_LAT   = 17;

    localparam logic signed [WIDE_W-1:0] WIDE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [WIDE_W:0]   SUM_MAX  = 65'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [WIDE_W:0]   SUM_MIN  = -SUM_MAX;

    typedef struct packed {
        logic                     clamp;
        logic signed [WIDE_W-1:0] v;
    } wide_t;

    function automatic wide_t sat_add(input wide_t a, input wide_t b);
        logic signed [WIDE_W:0] sum;
        wide_t r;
        sum = {a.v[WIDE_W-1], a.v} + {b.v[WIDE_W-1], b.v};
        r.clamp = a.clamp | b.clamp;
        r.v = sum[WIDE_W-1:0];
        if (sum > SUM_MAX)
        begin
            r.v = WIDE_MAX;
            r.clamp = 1'b1;
        end
        else if (sum < SUM_MIN)
        begin
            r.v = -WIDE_MAX;
            r.clamp = 1'b1;
        end
        return r;
    endfunction

    function automatic wide_t sat_sub(input wide_t a, input wide_t b);
        wide_t nb;
        nb.clamp = b.clamp;
        nb.v = -b.v;
        return sat_add(a, nb);
    endfunction

endpackage

`default_nettype wire

[hw/rtl/chp_delay.sv]
// Enabled register line that holds a value for a fixed number of stages.
`default_nettype none

module chp_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] line_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            line_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign dout = line_reg[DEPTH-1];

endmodule

`default_nettype wire

[hw/rtl/chp_qmul.sv]
// Four-stage saturating fixed-point multiplier on 64-bit two's-complement operands.
`default_nettype none

module chp_qmul #(
    parameter int FRAC_BITS = 16
) (
    input  logic          clk,
    input  logic          en,
    input  chp_pkg::wide_t a,
    input  chp_pkg::wide_t b,
    output chp_pkg::wide_t p
);

    logic [63:0]  ma_reg, mb_reg;
    logic         sgn1_reg, flg1_reg;
    logic [63:0]  p00_reg, p01_reg, p10_reg, p11_reg;
    logic         sgn2_reg, flg2_reg;
    logic [127:0] prod_reg;
    logic         sgn3_reg, flg3_reg;
    chp_pkg::wide_t p_reg;

    logic [127:0] prod_next;
    logic [127:0] shifted;
    logic         over;
    logic [62:0]  mag;
    chp_pkg::wide_t p_next;

    always_comb
    begin
        prod_next = {p11_reg, p00_reg} + (128'(p01_reg) << 32) + (128'(p10_reg) << 32);
        shifted   = prod_reg >> FRAC_BITS;
        over      = |shifted[127:63];
        mag       = over ? 63'h7FFF_FFFF_FFFF_FFFF : shifted[62:0];
        p_next.clamp = flg3_reg | over;
        p_next.v     = sgn3_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ma_reg   <= a.v[63] ? 64'(-a.v) : 64'(a.v);
            mb_reg   <= b.v[63] ? 64'(-b.v) : 64'(b.v);
            sgn1_reg <= a.v[63] ^ b.v[63];
            flg1_reg <= a.clamp | b.clamp;
            p00_reg  <= 64'(ma_reg[31:0])  * 64'(mb_reg[31:0]);
            p01_reg  <= 64'(ma_reg[31:0])  * 64'(mb_reg[63:32]);
            p10_reg  <= 64'(ma_reg[63:32]) * 64'(mb_reg[31:0]);
            p11_reg  <= 64'(ma_reg[63:32]) * 64'(mb_reg[63:32]);
            sgn2_reg <= sgn1_reg;
            flg2_reg <= flg1_reg;
            prod_reg <= prod_next;
            sgn3_reg <= sgn2_reg;
            flg3_reg <= flg2_reg;
            p_reg    <= p_next;
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

[hw/rtl/chp_divider.sv]
// Restoring divider, one quotient bit per pipeline stage, with fraction bits appended.
`default_nettype none

module chp_divider #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                             clk,
    input  logic                             en,
    input  logic [DATA_WIDTH:0]              num,
    input  logic [DATA_WIDTH:0]              den,
    output logic [DATA_WIDTH+FRAC_BITS:0]    quo
);

    localparam int QB = DATA_WIDTH + 1 + FRAC_BITS;
    localparam int RW = DATA_WIDTH + 1;

    logic [RW-1:0] rem_reg [QB];
    logic [QB-1:0] nrm_reg [QB];
    logic [RW-1:0] den_reg [QB];
    logic [QB-1:0] quo_reg [QB];

    for (genvar k = 0; k < QB; k++)
    begin : g_stage
        logic [RW-1:0] rem_in;
        logic [QB-1:0] nrm_in;
        logic [RW-1:0] den_in;
        logic [QB-1:0] quo_in;
        logic [RW:0]   trial;
        logic          ge;
        logic [RW:0]   diff;

        if (k == 0)
        begin : g_first
            assign rem_in = '0;
            assign nrm_in = {num, {FRAC_BITS{1'b0}}};
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign nrm_in = nrm_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        always_comb
        begin
            trial = {rem_in, nrm_in[QB-1]};
            ge    = trial >= {1'b0, den_in};
            diff  = trial - {1'b0, den_in};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? diff[RW-1:0] : trial[RW-1:0];
                nrm_reg[k] <= nrm_in << 1;
                den_reg[k] <= den_in;
                quo_reg[k] <= {quo_in[QB-2:0], ge};
            end
        end
    end

    assign quo = quo_reg[QB-1];

endmodule

`default_nettype wire

[hw/rtl/chp_eval.sv]
// Hermite basis polynomials and weighted sum, pipelined around dedicated multipliers.
`default_nettype none

module chp_eval #(
    parameter int FRAC_BITS = 16
) (
    input  logic           clk,
    input  logic           en,
    input  chp_pkg::wide_t tn,
    input  chp_pkg::wide_t x0,
    input  chp_pkg::wide_t x1,
    input  chp_pkg::wide_t p0,
    input  chp_pkg::wide_t p1,
    output chp_pkg::wide_t acc
);

    localparam int WB = $bits(chp_pkg::wide_t);
    localparam logic signed [chp_pkg::WIDE_W-1:0] ONE_V = 64'sd1 <<< FRAC_BITS;

    chp_pkg::wide_t one_w;
    chp_pkg::wide_t tt_reg, h0pre_reg;
    chp_pkg::wide_t tn2, tn3, tn_d4, h0pre_d;
    chp_pkg::wide_t dbl2_reg, h1_reg, h0_reg, tn2_d1_reg;
    chp_pkg::wide_t three2_reg, g0a_reg, g0a_d, three2_d;
    chp_pkg::wide_t two3_reg, g0_reg, g1_reg, h0_d, h1_d;
    chp_pkg::wide_t a0, a1, b0, b1;
    chp_pkg::wide_t s1_reg, s2_reg, s3_reg, b0_d1_reg, b1_d1_reg, b1_d2_reg;

    assign one_w = '{clamp: 1'b0, v: ONE_V};

    chp_qmul #(.FRAC_BITS(FRAC_BITS)) u_tn2 (.clk(clk), .en(en), .a(tn), .b(tn), .p(tn2));
    chp_qmul #(.FRAC_BITS(FRAC_BITS)) u_tn3 (.clk(clk), .en(en), .a(tn2), .b(tn_d4), .p(tn3));
    chp_qmul #(.FRAC_BITS(FRAC_BITS)) u_a0  (.clk(clk), .en(en), .a(x0), .b(g0_reg), .p(a0));
    chp_qmul #(.FRAC_BITS(FRAC_BITS)) u_a1  (.clk(clk), .en(en), .a(x1), .b(g1_reg), .p(a1));
    chp_qmul #(.FRAC_BITS(FRAC_BITS)) u_b0  (.clk(clk), .en(en), .a(p0), .b(h0_d), .p(b0));
    chp_qmul #(.FRAC_BITS(FRAC_BITS)) u_b1  (.clk(clk), .en(en), .a(p1), .b(h1_d), .p(b1));

    chp_delay #(.WIDTH(WB), .DEPTH(chp_pkg::QMUL_LAT)) u_tn_d
        (.clk(clk), .en(en), .din(tn), .dout(tn_d4));
    chp_delay #(.WIDTH(WB), .DEPTH(2)) u_h0pre_d
        (.clk(clk), .en(en), .din(h0pre_reg), .dout(h0pre_d));
    chp_delay #(.WIDTH(WB), .DEPTH(2)) u_g0a_d
        (.clk(clk), .en(en), .din(g0a_reg), .dout(g0a_d));
    chp_delay #(.WIDTH(WB), .DEPTH(3)) u_three2_d
        (.clk(clk), .en(en), .din(three2_reg), .dout(three2_d));
    chp_delay #(.WIDTH(WB), .DEPTH(5)) u_h0_d
        (.clk(clk), .en(en), .din(h0_reg), .dout(h0_d));
    chp_delay #(.WIDTH(WB), .DEPTH(5)) u_h1_d
        (.clk(clk), .en(en), .din(h1_reg), .dout(h1_d));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tt_reg     <= chp_pkg::sat_add(tn, tn);
            h0pre_reg  <= chp_pkg::sat_sub(one_w, tt_reg);
            dbl2_reg   <= chp_pkg::sat_add(tn2, tn2);
            h1_reg     <= chp_pkg::sat_sub(tn2, tn_d4);
            h0_reg     <= chp_pkg::sat_add(h0pre_d, tn2);
            tn2_d1_reg <= tn2;
            three2_reg <= chp_pkg::sat_add(tn2_d1_reg, dbl2_reg);
            g0a_reg    <= chp_pkg::sat_sub(one_w, three2_reg);
            two3_reg   <= chp_pkg::sat_add(tn3, tn3);
            g0_reg     <= chp_pkg::sat_add(g0a_d, two3_reg);
            g1_reg     <= chp_pkg::sat_sub(three2_d, two3_reg);
            s1_reg     <= chp_pkg::sat_add(a0, a1);
            b0_d1_reg  <= b0;
            b1_d1_reg  <= b1;
            s2_reg     <= chp_pkg::sat_add(s1_reg, b0_d1_reg);
            b1_d2_reg  <= b1_d1_reg;
            s3_reg     <= chp_pkg::sat_add(s2_reg, b1_d2_reg);
        end
    end

    assign acc = s3_reg;

endmodule

`default_nettype wire

[hw/rtl/cubic_hermite_interpolator_top.sv]
// Top level of the cubic Hermite interpolator: front end, divider, evaluation, output buffer.
//
// Input channel s_*: one item per query carries t, x0, t0, slope0, x1, t1, slope1,
// each a signed fixed-point word, packed into s_tdata from the lowest bits up.
// Output channel m_*: one item per query; m_tdata holds the interpolated value,
// m_tuser holds the zero-span and saturation flags.
// The pipeline depth is set by the restoring divider, one quotient bit per stage, and
// the three rounds of four-stage multipliers that follow.
// Throughput: one item per cycle while s_tready is high; every stage advances together.
// A two-entry output buffer absorbs a stalled receiver: the pipeline keeps taking
// items until the second entry fills, then s_tready drops until m_tready returns.
// Reset clears all valid bits and both buffer entries; no item is lost or repeated.
// When t1 equals t0 the result is x0 with the zero-span flag set.
`default_nettype none

`include "cubic_hermite_interpolator_top_macros.svh"

module cubic_hermite_interpolator_top #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // query_time, start_value, start_time, start_slope, end_value, end_time, end_slope
    input  logic [((chp_pkg::IN_FIELDS*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // interpolated_value
    output logic [((DATA_WIDTH+7)/8)*8-1:0] m_tdata,
    // zero_span, saturated
    output logic [1:0] m_tuser
);

    localparam int DW     = DATA_WIDTH;
    localparam int OW     = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int QB     = DATA_WIDTH + 1 + FRAC_BITS;
    localparam int CW     = (QB > chp_pkg::WIDE_W) ? QB : chp_pkg::WIDE_W;
    localparam int WB     = $bits(chp_pkg::wide_t);
    localparam int POS_T  = QB + 3;
    localparam int LAT    = POS_T + chp_pkg::EVAL_LAT + 1;
    localparam logic signed [chp_pkg::WIDE_W-1:0] HI_LIM =
        (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
    localparam logic signed [chp_pkg::WIDE_W-1:0] LO_LIM = -HI_LIM - 64'sd1;

    logic en;
    logic [LAT-1:0] vld_reg;
    logic out_valid_reg, skid_valid_reg, out_free;

    logic signed [DW:0]   d_reg, span_reg;
    logic signed [DW-1:0] x0_reg, x1_reg, s0_reg, s1_reg;
    logic [DW:0]          un_reg, ud_reg;
    logic                 neg_reg, zero_reg;

    logic [QB-1:0]        quo;
    logic                 neg_d;
    logic [CW-1:0]        qx;
    logic                 q_over;
    logic [chp_pkg::WIDE_W-1:0] q_mag;
    chp_pkg::wide_t       tn_reg;

    chp_pkg::wide_t       s0_w, s1_w, d_w, x0_w, x1_w;
    chp_pkg::wide_t       p0, p1, p0_d, p1_d, x0_m, x1_m, acc;
    logic [DW-1:0]        x0_f;
    logic                 zero_f;

    logic [DW-1:0]        res_val_reg;
    logic                 res_zero_reg, res_sat_reg;
    logic [DW-1:0]        out_val_reg, skid_val_reg;
    logic [1:0]           out_user_reg, skid_user_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign out_free = m_tready || !out_valid_reg;

    // Front end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg    <= $signed({s_tdata[DW-1], s_tdata[DW-1:0]})
                      - $signed({s_tdata[3*DW-1], s_tdata[2*DW +: DW]});
            span_reg <= $signed({s_tdata[6*DW-1], s_tdata[5*DW +: DW]})
                      - $signed({s_tdata[3*DW-1], s_tdata[2*DW +: DW]});
            x0_reg   <= s_tdata[1*DW +: DW];
            s0_reg   <= s_tdata[3*DW +: DW];
            x1_reg   <= s_tdata[4*DW +: DW];
            s1_reg   <= s_tdata[6*DW +: DW];
            un_reg   <= d_reg[DW] ? $unsigned(-d_reg) : $unsigned(d_reg);
            ud_reg   <= span_reg[DW] ? $unsigned(-span_reg) : $unsigned(span_reg);
            neg_reg  <= d_reg[DW] ^ span_reg[DW];
            zero_reg <= span_reg == '0;
        end
    end

    chp_divider #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
        .clk(clk), .en(en), .num(un_reg), .den(ud_reg), .quo(quo)
    );

    chp_delay #(.WIDTH(1), .DEPTH(QB)) u_neg_d
        (.clk(clk), .en(en), .din(neg_reg), .dout(neg_d));

    // Scale quotient to the wide format, clamp its integer part
    always_comb
    begin
        qx     = CW'(quo);
        q_over = (qx >> FRAC_BITS) > (CW'(chp_pkg::WIDE_MAX) >> FRAC_BITS);
        q_mag  = q_over ? chp_pkg::WIDE_W'(chp_pkg::WIDE_MAX) : qx[chp_pkg::WIDE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tn_reg.clamp <= q_over;
            tn_reg.v     <= neg_d ? -$signed(q_mag) : $signed(q_mag);
        end
    end

    assign s0_w = '{clamp: 1'b0, v: chp_pkg::WIDE_W'(s0_reg)};
    assign s1_w = '{clamp: 1'b0, v: chp_pkg::WIDE_W'(s1_reg)};
    assign d_w  = '{clamp: 1'b0, v: chp_pkg::WIDE_W'(d_reg)};
    assign x0_w = '{clamp: 1'b0, v: chp_pkg::WIDE_W'(x0_reg)};
    assign x1_w = '{clamp: 1'b0, v: chp_pkg::WIDE_W'(x1_reg)};

    chp_qmul #(.FRAC_BITS(FRAC_BITS)) u_p0 (.clk(clk), .en(en), .a(s0_w), .b(d_w), .p(p0));
    chp_qmul #(.FRAC_BITS(FRAC_BITS)) u_p1 (.clk(clk), .en(en), .a(s1_w), .b(d_w), .p(p1));

    chp_delay #(.WIDTH(WB), .DEPTH(POS_T + chp_pkg::EVAL_LEAD - 1 - chp_pkg::QMUL_LAT)) u_p0_d
        (.clk(clk), .en(en), .din(p0), .dout(p0_d));
    chp_delay #(.WIDTH(WB), .DEPTH(POS_T + chp_pkg::EVAL_LEAD - 1 - chp_pkg::QMUL_LAT)) u_p1_d
        (.clk(clk), .en(en), .din(p1), .dout(p1_d));
    chp_delay #(.WIDTH(WB), .DEPTH(POS_T + chp_pkg::EVAL_LEAD - 1)) u_x0_d
        (.clk(clk), .en(en), .din(x0_w), .dout(x0_m));
    chp_delay #(.WIDTH(WB), .DEPTH(POS_T + chp_pkg::EVAL_LEAD - 1)) u_x1_d
        (.clk(clk), .en(en), .din(x1_w), .dout(x1_m));
    chp_delay #(.WIDTH(DW), .DEPTH(POS_T + chp_pkg::EVAL_LAT - 1)) u_x0_f
        (.clk(clk), .en(en), .din(x0_reg), .dout(x0_f));
    chp_delay #(.WIDTH(1), .DEPTH(POS_T + chp_pkg::EVAL_LAT - 2)) u_zero_f
        (.clk(clk), .en(en), .din(zero_reg), .dout(zero_f));

    chp_eval #(.FRAC_BITS(FRAC_BITS)) u_eval (
        .clk(clk), .en(en), .tn(tn_reg), .x0(x0_m), .x1(x1_m), .p0(p0_d), .p1(p1_d),
        .acc(acc)
    );

    // Final clamp to the output width, zero-span override
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (zero_f)
            begin
                res_val_reg  <= x0_f;
                res_zero_reg <= 1'b1;
                res_sat_reg  <= 1'b0;
            end
            else if (acc.v > HI_LIM)
            begin
                res_val_reg  <= HI_LIM[DW-1:0];
                res_zero_reg <= 1'b0;
                res_sat_reg  <= 1'b1;
            end
            else if (acc.v < LO_LIM)
            begin
                res_val_reg  <= LO_LIM[DW-1:0];
                res_zero_reg <= 1'b0;
                res_sat_reg  <= 1'b1;
            end
            else
            begin
                res_val_reg  <= acc.v[DW-1:0];
                res_zero_reg <= 1'b0;
                res_sat_reg  <= acc.clamp;
            end
        end
    end

    // Valid line and output buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
            end
            if (out_free)
            begin
                out_valid_reg  <= skid_valid_reg || (en && vld_reg[LAT-1]);
                skid_valid_reg <= 1'b0;
            end
            else if (en && vld_reg[LAT-1])
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_val_reg  <= skid_valid_reg ? skid_val_reg : res_val_reg;
            out_user_reg <= skid_valid_reg ? skid_user_reg : {res_sat_reg, res_zero_reg};
        end
        else if (en)
        begin
            skid_val_reg  <= res_val_reg;
            skid_user_reg <= {res_sat_reg, res_zero_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OW'(out_val_reg);
    assign m_tuser  = out_user_reg;

    `CHP_ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid entry without output entry")
    `CHP_ASSERT_SAME(a_zero_not_sat, m_tvalid && m_tuser[0], !m_tuser[1], "zero span item flagged saturated")
    `CHP_ASSERT_NEXT(a_frozen_on_skid, skid_valid_reg, $stable(vld_reg), "pipeline moved while buffer full")
    `CHP_ASSERT_SAME(a_skid_fill, $rose(skid_valid_reg), $past(out_valid_reg && !m_tready), "skid filled while output free")

endmodule

`default_nettype wire
